>>> src/motor_power_model_and_current_limit_assert.svh
// assertion macros for the motor power model and current limit
`ifndef MOTOR_POWER_MODEL_AND_CURRENT_LIMIT_ASSERT_SVH
`define MOTOR_POWER_MODEL_AND_CURRENT_LIMIT_ASSERT_SVH

// same-cycle implication under reset
`define MPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
        else $error("mpm check failed");

// next-cycle implication under reset
`define MPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
        else $error("mpm check failed");

`endif

>>> src/mpm_pkg.sv
// shared types, constants and width helpers for the motor power model
package mpm_pkg;

    localparam int XW = 17;
    localparam int QW = 16;
    localparam int MPM_FIXED_LAT = 25;

    localparam logic [31:0] PWR_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PWR_MIN = 32'h8000_0000;
    localparam logic [QW-1:0] LIM_MAX = {QW{1'b1}};

    typedef enum logic [1:0] {
        CFG_SPEED_CURRENT = 2'd0,
        CFG_CURRENT_SQ    = 2'd1,
        CFG_SPEED_SQ      = 2'd2
    } cfg_idx_t;

    function automatic int mpm_root_width(input int frac);
        int bw;
        int ppw;
        int cw;
        int acw;
        int dw;
        bw  = 32 + XW;
        ppw = 32 + 2 * XW;
        cw  = ((ppw > XW + frac) ? ppw : XW + frac) + 1;
        acw = 32 + cw;
        dw  = ((2 * bw > acw + 2) ? 2 * bw : acw + 2) + 1;
        dw  = dw + (dw % 2);
        return dw / 2;
    endfunction

endpackage

>>> src/mpm_isqrt.sv
// pipelined integer square root, one result bit per stage
module mpm_isqrt
    import mpm_pkg::*;
#(
    parameter int RW     = 51,
    parameter int SIDE_W = 81
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [RW-1:0]     out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int DW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic              vld_reg  [1:RW];
    logic [RMW-1:0]    rem_reg  [1:RW];
    logic [RW-1:0]     root_reg [1:RW];
    logic [DW-1:0]     rad_reg  [1:RW];
    logic [SIDE_W-1:0] side_reg [1:RW];

    logic              src_vld  [0:RW-1];
    logic [RMW-1:0]    src_rem  [0:RW-1];
    logic [RW-1:0]     src_root [0:RW-1];
    logic [DW-1:0]     src_rad  [0:RW-1];
    logic [SIDE_W-1:0] src_side [0:RW-1];

    assign src_vld[0]  = in_vld;
    assign src_rem[0]  = '0;
    assign src_root[0] = '0;
    assign src_rad[0]  = in_rad;
    assign src_side[0] = in_side;

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RMW:0] cur_rem;
        logic [RMW:0] trial;
        logic [RMW:0] diff;
        logic         ge;

        if (k > 0)
        begin : g_src
            assign src_vld[k]  = vld_reg[k];
            assign src_rem[k]  = rem_reg[k];
            assign src_root[k] = root_reg[k];
            assign src_rad[k]  = rad_reg[k];
            assign src_side[k] = side_reg[k];
        end

        assign cur_rem = {src_rem[k][RW:0], src_rad[k][DW-1 -: 2]};
        assign trial   = {1'b0, src_root[k], 2'b01};
        assign ge      = (cur_rem >= trial);
        assign diff    = cur_rem - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= src_vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? diff[RMW-1:0] : cur_rem[RMW-1:0];
            root_reg[k+1] <= {src_root[k][RW-2:0], ge};
            rad_reg[k+1]  <= {src_rad[k][DW-3:0], 2'b00};
            side_reg[k+1] <= src_side[k];
        end
    end

    assign out_vld  = vld_reg[RW];
    assign out_root = root_reg[RW];
    assign out_side = side_reg[RW];

endmodule

>>> src/mpm_div.sv
// pipelined restoring divider, one quotient bit per stage
module mpm_div
    import mpm_pkg::*;
#(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 34
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [QW-1:0]     out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int EW = NUM_W + DEN_W;

    logic              vld_reg  [1:QW];
    logic [NUM_W-1:0]  rem_reg  [1:QW];
    logic [DEN_W-1:0]  den_reg  [1:QW];
    logic [QW-1:0]     quo_reg  [1:QW];
    logic [SIDE_W-1:0] side_reg [1:QW];

    logic              src_vld  [0:QW-1];
    logic [NUM_W-1:0]  src_rem  [0:QW-1];
    logic [DEN_W-1:0]  src_den  [0:QW-1];
    logic [QW-1:0]     src_quo  [0:QW-1];
    logic [SIDE_W-1:0] src_side [0:QW-1];

    assign src_vld[0]  = in_vld;
    assign src_rem[0]  = in_num;
    assign src_den[0]  = in_den;
    assign src_quo[0]  = '0;
    assign src_side[0] = in_side;

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [EW-1:0] rem_x;
        logic [EW-1:0] den_x;
        logic [EW-1:0] diff;
        logic          ge;

        if (j > 0)
        begin : g_src
            assign src_vld[j]  = vld_reg[j];
            assign src_rem[j]  = rem_reg[j];
            assign src_den[j]  = den_reg[j];
            assign src_quo[j]  = quo_reg[j];
            assign src_side[j] = side_reg[j];
        end

        assign rem_x = {{DEN_W{1'b0}}, src_rem[j]};
        assign den_x = {{NUM_W{1'b0}}, src_den[j]} << (QW - 1 - j);
        assign ge    = (rem_x >= den_x);
        assign diff  = rem_x - den_x;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= src_vld[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= ge ? diff[NUM_W-1:0] : src_rem[j];
            den_reg[j+1]  <= src_den[j];
            quo_reg[j+1]  <= {src_quo[j][QW-2:0], ge};
            side_reg[j+1] <= src_side[j];
        end
    end

    assign out_vld  = vld_reg[QW];
    assign out_quo  = quo_reg[QW];
    assign out_side = side_reg[QW];

endmodule

>>> src/motor_power_model_and_current_limit.sv
// top level: quadratic motor power estimate and torque-current limit
//
// command channel: a beat is taken on each clock edge with start high and busy
// low; busy is high in reset and up to the first edge after it, so a new beat
// may come every cycle after that.
// each beat carries iq_current, motor_speed and power_limit.
// each result passes the input register, stages s1 to s6, the square root,
// the numerator register, the divider and the result register; R, the root
// width from the coefficient fraction bits, is 51 at the defaults, and the square root takes one stage per root bit.
// done marks power_estimate, current_limit and limit_invalid for one cycle;
// the receiver cannot hold results off, nothing is buffered or dropped.
// throughput: one beat per clock, beats in flight travel with their valids.
// coefficient writes use cfg_valid/cfg_ready with cfg_index and cfg_data,
// always ready; write them only while no beat is in flight.
// reset clears the pipeline valids and all three coefficients to zero.
// a non-positive current-squared coefficient gives limit_invalid and a zero
// limit, while the power estimate is still produced.
module motor_power_model_and_current_limit
    import mpm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 24,
    parameter int SAMPLE_WIDTH   = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] iq_current,
    input  logic [15:0] motor_speed,
    input  logic [15:0] power_limit,
    output logic        done,
    output logic [31:0] power_estimate,
    output logic [15:0] current_limit,
    output logic        limit_invalid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BW   = 32 + XW;
    localparam int PPW  = 32 + 2 * XW;
    localparam int PSW  = PPW + 2;
    localparam int CW   = ((PPW > XW + COEF_FRAC_BITS) ? PPW : XW + COEF_FRAC_BITS) + 1;
    localparam int CL   = 34;
    localparam int CH   = CW - CL;
    localparam int ACW  = 32 + CW;
    localparam int BL   = 25;
    localparam int RW   = mpm_root_width(COEF_FRAC_BITS);
    localparam int DW   = 2 * RW;
    localparam int NW   = RW + 2;
    localparam int DENW = 33;
    localparam int SQS  = 32 + BW;
    localparam int DVS  = 34;

    logic signed [31:0] k1_reg;
    logic signed [31:0] k2_reg;
    logic signed [31:0] k3_reg;
    logic               busy_reg;

    // coefficient registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
            k3_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SPEED_CURRENT: k1_reg <= cfg_data;
                CFG_CURRENT_SQ:    k2_reg <= cfg_data;
                CFG_SPEED_SQ:      k3_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    // sample extension
    logic signed [XW-1:0] cur_x;
    logic signed [XW-1:0] spd_x;

    if (SAMPLE_WIDTH < 16)
    begin : g_narrow
        assign cur_x = {{(XW-SAMPLE_WIDTH){iq_current[SAMPLE_WIDTH-1]}},
                        iq_current[SAMPLE_WIDTH-1:0]};
        assign spd_x = {{(XW-SAMPLE_WIDTH){motor_speed[SAMPLE_WIDTH-1]}},
                        motor_speed[SAMPLE_WIDTH-1:0]};
    end
    else if (SAMPLE_WIDTH == 16)
    begin : g_exact
        assign cur_x = {iq_current[15], iq_current};
        assign spd_x = {motor_speed[15], motor_speed};
    end
    else
    begin : g_wide
        assign cur_x = {1'b0, iq_current};
        assign spd_x = {1'b0, motor_speed};
    end

    // stage 0: input beat
    logic                 s0_vld_reg;
    logic signed [XW-1:0] s0_cur_reg;
    logic signed [XW-1:0] s0_spd_reg;
    logic [15:0]          s0_plim_reg;

    // stage 1: first products
    logic                   s1_vld_reg;
    logic signed [BW-1:0]   s1_b_reg;
    logic signed [2*XW-1:0] s1_cc_reg;
    logic signed [2*XW-1:0] s1_ww_reg;
    logic signed [XW-1:0]   s1_cur_reg;
    logic [15:0]            s1_plim_reg;

    // stage 2: power terms
    logic                  s2_vld_reg;
    logic signed [PPW-1:0] s2_pb_reg;
    logic signed [PPW-1:0] s2_pc_reg;
    logic signed [PPW-1:0] s2_pw_reg;
    logic signed [BW-1:0]  s2_b_reg;
    logic [15:0]           s2_plim_reg;

    // stage 3: sum and constant term
    logic                  s3_vld_reg;
    logic signed [PSW-1:0] s3_sum_reg;
    logic signed [CW-1:0]  s3_c_reg;
    logic signed [BW-1:0]  s3_b_reg;

    // stage 4: saturation and partial products
    logic                       s4_vld_reg;
    logic [31:0]                s4_pwr_reg;
    logic signed [32+CL:0]      s4_aclo_reg;
    logic signed [32+CH-1:0]    s4_achi_reg;
    logic signed [BW+BL:0]      s4_bblo_reg;
    logic signed [2*BW-BL-1:0]  s4_bbhi_reg;
    logic signed [BW-1:0]       s4_b_reg;

    // stage 5: merged products
    logic                   s5_vld_reg;
    logic [31:0]            s5_pwr_reg;
    logic signed [ACW-1:0]  s5_ac_reg;
    logic signed [2*BW-1:0] s5_bb_reg;
    logic signed [BW-1:0]   s5_b_reg;

    // stage 6: discriminant
    logic                 s6_vld_reg;
    logic [DW-1:0]        s6_d_reg;
    logic [31:0]          s6_pwr_reg;
    logic signed [BW-1:0] s6_b_reg;

    logic [CW-1:0]  plim_sh;
    logic [PSW-1:0] p_sh;
    logic           p_fits;
    logic [DW:0]    bb_x;
    logic [DW:0]    ac_x;
    logic [DW:0]    d_full;

    assign plim_sh = {{(CW-16){1'b0}}, s2_plim_reg} << COEF_FRAC_BITS;
    assign p_sh    = s3_sum_reg >>> COEF_FRAC_BITS;
    assign p_fits  = (&p_sh[PSW-1:31]) || !(|p_sh[PSW-1:31]);
    assign bb_x    = {{(DW+1-2*BW){s5_bb_reg[2*BW-1]}}, s5_bb_reg};
    assign ac_x    = {{(DW+1-ACW){s5_ac_reg[ACW-1]}}, s5_ac_reg};
    assign d_full  = s5_ac_reg[ACW-1] ? (bb_x - {ac_x[DW-2:0], 2'b00}) : bb_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy_reg;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_cur_reg  <= cur_x;
        s0_spd_reg  <= spd_x;
        s0_plim_reg <= power_limit;

        s1_b_reg    <= k1_reg * s0_spd_reg;
        s1_cc_reg   <= s0_cur_reg * s0_cur_reg;
        s1_ww_reg   <= s0_spd_reg * s0_spd_reg;
        s1_cur_reg  <= s0_cur_reg;
        s1_plim_reg <= s0_plim_reg;

        s2_pb_reg   <= s1_b_reg * s1_cur_reg;
        s2_pc_reg   <= k2_reg * s1_cc_reg;
        s2_pw_reg   <= k3_reg * s1_ww_reg;
        s2_b_reg    <= s1_b_reg;
        s2_plim_reg <= s1_plim_reg;

        s3_sum_reg  <= {{2{s2_pb_reg[PPW-1]}}, s2_pb_reg}
                     + {{2{s2_pc_reg[PPW-1]}}, s2_pc_reg}
                     + {{2{s2_pw_reg[PPW-1]}}, s2_pw_reg};
        s3_c_reg    <= {{(CW-PPW){s2_pw_reg[PPW-1]}}, s2_pw_reg} - plim_sh;
        s3_b_reg    <= s2_b_reg;

        s4_pwr_reg  <= p_fits ? p_sh[31:0] : (p_sh[PSW-1] ? PWR_MIN : PWR_MAX);
        s4_aclo_reg <= k2_reg * $signed({1'b0, s3_c_reg[CL-1:0]});
        s4_achi_reg <= k2_reg * $signed(s3_c_reg[CW-1:CL]);
        s4_bblo_reg <= s3_b_reg * $signed({1'b0, s3_b_reg[BL-1:0]});
        s4_bbhi_reg <= s3_b_reg * $signed(s3_b_reg[BW-1:BL]);
        s4_b_reg    <= s3_b_reg;

        s5_pwr_reg  <= s4_pwr_reg;
        s5_ac_reg   <= {s4_achi_reg, {CL{1'b0}}}
                     + {{(ACW-33-CL){s4_aclo_reg[32+CL]}}, s4_aclo_reg};
        s5_bb_reg   <= {s4_bbhi_reg, {BL{1'b0}}}
                     + {{(BW-BL-1){s4_bblo_reg[BW+BL]}}, s4_bblo_reg};
        s5_b_reg    <= s4_b_reg;

        s6_d_reg    <= d_full[DW-1:0];
        s6_pwr_reg  <= s5_pwr_reg;
        s6_b_reg    <= s5_b_reg;
    end

    // square root
    logic              sq_vld;
    logic [RW-1:0]     sq_root;
    logic [SQS-1:0]    sq_side;

    mpm_isqrt #(
        .RW     (RW),
        .SIDE_W (SQS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s6_vld_reg),
        .in_rad   (s6_d_reg),
        .in_side  ({s6_pwr_reg, s6_b_reg}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // numerator of the root formula
    logic                 n_vld_reg;
    logic signed [NW-1:0] n_reg;
    logic [31:0]          n_pwr_reg;
    logic signed [BW-1:0] sq_b;

    assign sq_b = sq_side[BW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= 1'b0;
        end
        else
        begin
            n_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= {2'b00, sq_root} - {{(NW-BW){sq_b[BW-1]}}, sq_b};
        n_pwr_reg <= sq_side[SQS-1:BW];
    end

    // divide by twice the current-squared coefficient
    logic [DENW-1:0]         den;
    logic                    n_zero;
    logic                    n_big;
    logic                    dv_vld;
    logic [QW-1:0]           dv_quo;
    logic [DVS-1:0]          dv_side;
    logic [NW-2+DENW+QW:0]   num_x;
    logic [NW-2+DENW+QW:0]   lim_x;

    assign den    = {k2_reg, 1'b0};
    assign n_zero = n_reg[NW-1] || (n_reg == '0);
    assign num_x  = {{(DENW+QW){1'b0}}, n_reg[NW-2:0]};
    assign lim_x  = {{(NW-1){1'b0}}, den, {QW{1'b0}}};
    assign n_big  = (num_x >= lim_x);

    mpm_div #(
        .NUM_W  (NW - 1),
        .DEN_W  (DENW),
        .SIDE_W (DVS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (n_vld_reg),
        .in_num   (n_reg[NW-2:0]),
        .in_den   (den),
        .in_side  ({n_pwr_reg, n_zero, n_big}),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // result register
    logic          done_reg;
    logic [31:0]   power_estimate_reg;
    logic [QW-1:0] current_limit_reg;
    logic          limit_invalid_reg;
    logic          k2_bad;

    assign k2_bad = k2_reg[31] || (k2_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        power_estimate_reg <= dv_side[DVS-1:2];
        limit_invalid_reg  <= k2_bad;
        if (k2_bad || dv_side[1])
        begin
            current_limit_reg <= '0;
        end
        else if (dv_side[0])
        begin
            current_limit_reg <= LIM_MAX;
        end
        else
        begin
            current_limit_reg <= dv_quo;
        end
    end

    assign done           = done_reg;
    assign power_estimate = power_estimate_reg;
    assign current_limit  = current_limit_reg;
    assign limit_invalid  = limit_invalid_reg;

endmodule

>>> src/mpm_checker.sv
// port-level checks for the motor power model, bound to the top level
`include "motor_power_model_and_current_limit_assert.svh"

module mpm_checker
    import mpm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 24
)(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] current_limit,
    input logic        limit_invalid
);

    localparam int LAT = MPM_FIXED_LAT + mpm_root_width(COEF_FRAC_BITS);

    // every accepted beat gives a result after the fixed latency
    `MPM_ASSERT_IMPL(a_beat_done, clk, rst_n, start && !busy, ##LAT done)

    // no result without a beat that long ago
    `MPM_ASSERT_IMPL(a_done_beat, clk, rst_n, done, $past(start && !busy, LAT))

    // an invalid coefficient forces a zero limit
    `MPM_ASSERT_IMPL(a_inv_zero, clk, rst_n, done && limit_invalid, current_limit == '0)

    // once out of reset the block stays ready
    `MPM_ASSERT_NEXT(a_busy_low, clk, rst_n, !busy, !busy)

endmodule

bind motor_power_model_and_current_limit mpm_checker #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
) u_mpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .current_limit (current_limit),
    .limit_invalid (limit_invalid)
);
